// File: hdl/assert_macros.svh
// assertion macros shared by the rtl files
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication, checked outside reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// File: hdl/ufst_pkg.sv
// shared constants for the spanning tree weight block
// no dependencies
package ufst_pkg;

	localparam int VTX_IN_BITS    = 16;
	localparam int WEIGHT_IN_BITS = 16;
	localparam int TOTAL_BITS     = 32;
	localparam int COUNT_BITS     = 17;
	localparam int STATUS_BITS    = 2;
	localparam int RANK_BITS      = 5;

	typedef logic [RANK_BITS-1:0]   rank_t;
	typedef logic [STATUS_BITS-1:0] status_t;
	typedef logic [TOTAL_BITS-1:0]  total_t;
	typedef logic [COUNT_BITS-1:0]  count_t;

	localparam rank_t  RANK_ZERO     = '0;
	localparam rank_t  RANK_MAX      = '1;
	localparam count_t VCOUNT_RESET  = 17'd65536;

	localparam logic FUNC_ADD   = 1'b0;
	localparam logic FUNC_CLEAR = 1'b1;

	localparam status_t ST_JOINED    = 2'd0;
	localparam status_t ST_CONNECTED = 2'd1;
	localparam status_t ST_RANGE     = 2'd2;
	localparam status_t ST_CLEARED   = 2'd3;

endpackage

// File: hdl/ufst_ram.sv
// generic simple dual-port ram, one write port and one registered read port
// no dependencies
module ufst_ram #(
	parameter int WIDTH = 21,
	parameter int DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: hdl/union_find_spanning_tree_weight_top.sv
// Kruskal spanning tree weight over a disjoint-set forest (union by rank, path
// compression); uses ufst_pkg, ufst_ram and assert_macros.svh. Parent and rank
// of every vertex share one word of a single ram with a registered read, and
// every find step is issued in S_RD, then evaluated and written back in S_EV;
// each endpoint's path is walked once to find its root and once to compress
// it, and two roots of equal rank take an extra rank update in S_LINK1. An
// index out of range goes straight to the result. A clear transaction writes
// one vertex per cycle up to the effective vertex count and zeroes the total.
// After reset all MAX_VERTICES ram entries are initialized one per cycle,
// during which in_stall stays high; the config register may be written
// then or whenever no transaction is in flight. One result is delivered per
// transaction through an output register, so a new edge is taken while a
// result waits.
`include "assert_macros.svh"

module union_find_spanning_tree_weight_top import ufst_pkg::*; #(
	parameter int MAX_VERTICES = 65536,
	parameter int WEIGHT_BITS  = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_wr_en,
	input  logic [COUNT_BITS-1:0]     cfg_wr_data,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic                      func,
	input  logic [VTX_IN_BITS-1:0]    edge_from,
	input  logic [VTX_IN_BITS-1:0]    edge_to,
	input  logic [WEIGHT_IN_BITS-1:0] edge_weight,
	input  logic                      last_edge,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [STATUS_BITS-1:0]    status,
	output logic [TOTAL_BITS-1:0]     tree_weight,
	output logic                      tree_done
);

	localparam int VW       = $clog2(MAX_VERTICES);
	localparam int RW       = VW + RANK_BITS;
	localparam int NW       = $clog2(MAX_VERTICES + 1);
	localparam int CW       = (NW > COUNT_BITS) ? NW : COUNT_BITS;
	localparam int WM       = (WEIGHT_BITS < WEIGHT_IN_BITS) ? WEIGHT_BITS : WEIGHT_IN_BITS;
	localparam int SUM_BITS = TOTAL_BITS + 1;

	localparam logic [2:0] S_INIT  = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_CLR   = 3'd2;
	localparam logic [2:0] S_RD    = 3'd3;
	localparam logic [2:0] S_EV    = 3'd4;
	localparam logic [2:0] S_LINK0 = 3'd5;
	localparam logic [2:0] S_LINK1 = 3'd6;
	localparam logic [2:0] S_DONE  = 3'd7;

	logic [2:0]                state_q;
	count_t                    vcount_q;
	logic [VW-1:0]             cnt_q;
	logic [VW-1:0]             ptr_q;
	logic [VW-1:0]             root_q;
	rank_t                     rank_q;
	logic [VW-1:0]             root_a_q;
	rank_t                     rank_a_q;
	logic                      side_q;
	logic                      cmp_q;
	logic [VW-1:0]             from_q;
	logic [VW-1:0]             to_q;
	logic [WEIGHT_IN_BITS-1:0] wgt_q;
	logic                      last_q;
	total_t                    total_q;
	status_t                   res_status_q;
	logic                      out_valid_q;
	status_t                   status_q;
	total_t                    tree_weight_q;
	logic                      tree_done_q;

	logic                      ram_we;
	logic [VW-1:0]             ram_waddr;
	logic [RW-1:0]             ram_wdata;
	logic                      ram_re;
	logic [RW-1:0]             ram_rdata;
	logic [VW-1:0]             rd_parent;
	rank_t                     rd_rank;

	logic [CW-1:0]             n_eff;
	logic                      out_of_range;
	logic                      clr_last;
	logic                      init_last;
	logic                      find_end;
	logic [SUM_BITS-1:0]       sum;
	total_t                    total_next;
	rank_t                     rank_inc;

	ufst_ram #(
		.WIDTH (RW),
		.DEPTH (MAX_VERTICES)
	) u_forest (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ptr_q),
		.rdata (ram_rdata)
	);

	assign rd_parent = ram_rdata[VW-1:0];
	assign rd_rank   = ram_rdata[RW-1:VW];

	// effective vertex count: zero acts as one, clamp to capacity
	always_comb begin
		if (vcount_q == '0) begin
			n_eff = CW'(1);
		end else if (CW'(vcount_q) > CW'(MAX_VERTICES)) begin
			n_eff = CW'(MAX_VERTICES);
		end else begin
			n_eff = CW'(vcount_q);
		end
	end

	assign out_of_range = (CW'(edge_from) >= n_eff) || (CW'(edge_to) >= n_eff);
	assign clr_last     = (CW'(cnt_q) == (n_eff - CW'(1)));
	assign init_last    = (cnt_q == VW'(MAX_VERTICES - 1));
	assign find_end     = cmp_q && (ptr_q == root_q);
	assign sum          = {1'b0, total_q} + SUM_BITS'(wgt_q[WM-1:0]);
	assign total_next   = sum[TOTAL_BITS] ? '1 : sum[TOTAL_BITS-1:0];
	assign rank_inc     = (rank_q == RANK_MAX) ? RANK_MAX : rank_q + rank_t'(1);

	// memory port control
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = cnt_q;
		ram_wdata = {RANK_ZERO, cnt_q};
		ram_re    = 1'b0;
		unique case (state_q) inside
			S_INIT, S_CLR: begin
				ram_we = 1'b1;
			end
			S_RD: begin
				ram_re = !find_end;
			end
			S_EV: begin
				// path compression write-back
				ram_we    = cmp_q;
				ram_waddr = ptr_q;
				ram_wdata = {rd_rank, root_q};
			end
			S_LINK0: begin
				ram_we = (root_a_q != root_q);
				if (rank_a_q < rank_q) begin
					ram_waddr = root_a_q;
					ram_wdata = {rank_a_q, root_q};
				end else begin
					ram_waddr = root_q;
					ram_wdata = {rank_q, root_a_q};
				end
			end
			S_LINK1: begin
				ram_we    = 1'b1;
				ram_waddr = root_a_q;
				ram_wdata = {rank_inc, root_a_q};
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_INIT;
			vcount_q      <= VCOUNT_RESET;
			cnt_q         <= '0;
			ptr_q         <= '0;
			root_q        <= '0;
			rank_q        <= RANK_ZERO;
			root_a_q      <= '0;
			rank_a_q      <= RANK_ZERO;
			side_q        <= 1'b0;
			cmp_q         <= 1'b0;
			from_q        <= '0;
			to_q          <= '0;
			wgt_q         <= '0;
			last_q        <= 1'b0;
			total_q       <= '0;
			res_status_q  <= ST_JOINED;
			out_valid_q   <= 1'b0;
			status_q      <= ST_JOINED;
			tree_weight_q <= '0;
			tree_done_q   <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				vcount_q <= cfg_wr_data;
			end
			if (out_valid_q && !out_stall && (state_q != S_DONE)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_INIT: begin
					cnt_q <= cnt_q + VW'(1);
					if (init_last) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						from_q <= VW'(edge_from);
						to_q   <= VW'(edge_to);
						ptr_q  <= VW'(edge_from);
						wgt_q  <= edge_weight;
						last_q <= last_edge;
						side_q <= 1'b0;
						cmp_q  <= 1'b0;
						cnt_q  <= '0;
						if (func == FUNC_CLEAR) begin
							res_status_q <= ST_CLEARED;
							state_q      <= S_CLR;
						end else if (out_of_range) begin
							res_status_q <= ST_RANGE;
							state_q      <= S_DONE;
						end else begin
							state_q <= S_RD;
						end
					end
				end
				S_CLR: begin
					cnt_q <= cnt_q + VW'(1);
					if (clr_last) begin
						total_q <= '0;
						state_q <= S_DONE;
					end
				end
				S_RD: begin
					if (!find_end) begin
						state_q <= S_EV;
					end else if (!side_q) begin
						// first root settled, start on the second endpoint
						root_a_q <= root_q;
						rank_a_q <= rank_q;
						side_q   <= 1'b1;
						cmp_q    <= 1'b0;
						ptr_q    <= to_q;
					end else begin
						state_q <= S_LINK0;
					end
				end
				S_EV: begin
					state_q <= S_RD;
					if (!cmp_q && (rd_parent == ptr_q)) begin
						root_q <= ptr_q;
						rank_q <= rd_rank;
						cmp_q  <= 1'b1;
						ptr_q  <= side_q ? to_q : from_q;
					end else begin
						ptr_q <= rd_parent;
					end
				end
				S_LINK0: begin
					if (root_a_q == root_q) begin
						res_status_q <= ST_CONNECTED;
						state_q      <= S_DONE;
					end else begin
						res_status_q <= ST_JOINED;
						total_q      <= total_next;
						if (rank_a_q == rank_q) begin
							state_q <= S_LINK1;
						end else begin
							state_q <= S_DONE;
						end
					end
				end
				S_LINK1: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q   <= 1'b1;
						status_q      <= res_status_q;
						tree_weight_q <= total_q;
						tree_done_q   <= last_q;
						state_q       <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_stall    = (state_q != S_IDLE);
	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign tree_weight = tree_weight_q;
	assign tree_done   = tree_done_q;

	// writes and reads of the forest ram never share a cycle
	`ASSERT_IMPL(a_no_rw_overlap, clk, arst_n, ram_we, !ram_re)
	// a compressed node never ends up pointing at itself
	`ASSERT_IMPL(a_cmp_not_self, clk, arst_n, ram_we && (state_q == S_EV),
		ram_wdata[VW-1:0] != ram_waddr)
	// linking never lowers the running total
	`ASSERT_NEXT(a_total_mono, clk, arst_n, state_q == S_LINK0, total_q >= $past(total_q))
	// a result is only loaded on the way back to idle
	`ASSERT_NEXT(a_load_to_idle, clk, arst_n,
		(state_q == S_DONE) && (!out_valid_q || !out_stall), out_valid_q && (state_q == S_IDLE))

endmodule
